FILE: rtl/core/sob_pkg.sv
// Shared types and constants for the straight-alpha over blend.
// Used by sob_front, sob_div and straight_alpha_over_blend; no dependencies.
package sob_pkg;

	localparam int CHAN_W    = 8;
	localparam int NUM_CH    = 3;
	localparam int PROD_W    = 16;               // 8x8 product
	localparam int TERM_W    = 24;               // 16x8 product
	localparam int NUM_W     = 25;               // blend numerator, max about 16.6M
	localparam int DEN_W     = 16;               // out_alpha*255
	localparam int DIV_STEPS = 10;               // quotient bits 9..0, bit 9/8 saturate
	localparam int QUO_W     = DIV_STEPS;
	localparam int RECIP_W   = 17;
	localparam logic [RECIP_W-1:0] RECIP_255 = 17'd32897;  // 2^23/255, exact for 16-bit x
	localparam int RECIP_SH  = 23;
	localparam logic [7:0] ROUND_255 = 8'd127;
	localparam logic [7:0] CHAN_MAX  = 8'd255;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_BLUE  = 2'd2;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t              color;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	// front end stage 1: raw 8x8 products
	typedef struct packed {
		logic [CHAN_W-1:0]              cov;
		logic [CHAN_W-1:0]              inv;
		logic [PROD_W-1:0]              da_inv;
		logic [NUM_CH-1:0][PROD_W-1:0]  src_cov;
		logic [NUM_CH-1:0][PROD_W-1:0]  dst_da;
		pixel_t                         pix;
	} s1_t;

	// front end stage 2: output alpha and the two numerator terms
	typedef struct packed {
		logic [CHAN_W-1:0]              cov;
		logic [CHAN_W-1:0]              oa;
		logic [NUM_CH-1:0][TERM_W-1:0]  term_src;
		logic [NUM_CH-1:0][TERM_W-1:0]  term_dst;
		pixel_t                         pix;
	} s2_t;

	// handoff to the divider
	typedef struct packed {
		logic [NUM_CH-1:0][NUM_W-1:0]   num;
		logic [DEN_W-1:0]               den;
		logic                           bypass;
		logic [CHAN_W-1:0]              oa;
		pixel_t                         pix;
	} div_in_t;

	// one restoring divider stage
	typedef struct packed {
		logic [NUM_CH-1:0][NUM_W-1:0]   rem;
		logic [NUM_CH-1:0][QUO_W-1:0]   quo;
		logic [DEN_W-1:0]               den;
		logic                           bypass;
		logic [CHAN_W-1:0]              oa;
		pixel_t                         pix;
	} div_step_t;

	function automatic logic [CHAN_W-1:0] rgb_pick(rgb_t c, int ch);
		logic [CHAN_W-1:0] r;
		case (ch)
			0:       r = c.red;
			1:       r = c.green;
			default: r = c.blue;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/sob_front.sv
// Front end of the blend: products, output alpha, numerator and denominator.
// Three pipeline stages with valid/ready; depends on sob_pkg.
module sob_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       cov_in,
	input  sob_pkg::pixel_t  pix_in,
	input  sob_pkg::rgb_t    layer,
	output logic             out_valid,
	input  logic             out_ready,
	output sob_pkg::div_in_t out_word
);
	import sob_pkg::*;

	s1_t     s1_d, data_s1;
	s2_t     s2_d, data_s2;
	div_in_t s3_d, data_s3;
	logic    vld_s1, vld_s2, vld_s3;
	logic    take_s1, take_s2, take_s3;

	// a stage loads when empty or when its word moves on
	assign take_s3  = !vld_s3 || out_ready;
	assign take_s2  = !vld_s2 || take_s3;
	assign take_s1  = !vld_s1 || take_s2;
	assign in_ready = take_s1;

	// stage 1: 8x8 multiplies
	always_comb begin
		s1_d.cov    = cov_in;
		s1_d.inv    = CHAN_MAX - cov_in;
		s1_d.da_inv = PROD_W'(pix_in.alpha) * PROD_W'(CHAN_MAX - cov_in);
		for (int c = 0; c < NUM_CH; c++) begin
			s1_d.src_cov[c] = PROD_W'(rgb_pick(layer, c)) * PROD_W'(cov_in);
			s1_d.dst_da[c]  = PROD_W'(rgb_pick(pix_in.color, c)) * PROD_W'(pix_in.alpha);
		end
		s1_d.pix = pix_in;
	end

	// stage 2: alpha = cov + round(da*inv/255) by reciprocal; terms src*cov*255, dst*da*inv
	logic [PROD_W-1:0]           round_x;
	logic [PROD_W+RECIP_W-1:0]   recip_p;
	logic [CHAN_W:0]             oa_sum;
	always_comb begin
		round_x = data_s1.da_inv + PROD_W'(ROUND_255);
		recip_p = (PROD_W+RECIP_W)'(round_x) * (PROD_W+RECIP_W)'(RECIP_255);
		// sum never exceeds 255: the rounded term is at most inv
		oa_sum  = (CHAN_W+1)'(data_s1.cov) + (CHAN_W+1)'(recip_p[RECIP_SH +: CHAN_W]);
		s2_d.cov = data_s1.cov;
		s2_d.oa  = oa_sum[CHAN_W-1:0];
		for (int c = 0; c < NUM_CH; c++) begin
			s2_d.term_src[c] = (TERM_W'(data_s1.src_cov[c]) << 8) - TERM_W'(data_s1.src_cov[c]);
			s2_d.term_dst[c] = TERM_W'(data_s1.dst_da[c]) * TERM_W'(data_s1.inv);
		end
		s2_d.pix = data_s1.pix;
	end

	// stage 3: den = oa*255, num = terms + den/2
	always_comb begin
		s3_d.den = (DEN_W'(data_s2.oa) << 8) - DEN_W'(data_s2.oa);
		for (int c = 0; c < NUM_CH; c++) begin
			s3_d.num[c] = NUM_W'(data_s2.term_src[c]) + NUM_W'(data_s2.term_dst[c])
				+ NUM_W'(s3_d.den >> 1);
		end
		s3_d.bypass = (data_s2.cov == '0);
		s3_d.oa     = data_s2.oa;
		s3_d.pix    = data_s2.pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (take_s1) vld_s1 <= in_valid;
			if (take_s2) vld_s2 <= vld_s1;
			if (take_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) data_s1 <= s1_d;
		if (take_s2 && vld_s1)   data_s2 <= s2_d;
		if (take_s3 && vld_s2)   data_s3 <= s3_d;
	end

	assign out_valid = vld_s3;
	assign out_word  = data_s3;

endmodule

FILE: rtl/core/sob_div.sv
// Pipelined restoring divider, one quotient bit per stage for all three channels,
// then clamp, pass-through select and output register. Depends on sob_pkg.
module sob_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sob_pkg::div_in_t in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output sob_pkg::pixel_t  out_pix
);
	import sob_pkg::*;

	div_step_t          div_s [DIV_STEPS];
	logic               div_vld_s [DIV_STEPS];
	div_step_t          prev [DIV_STEPS];
	logic               prev_vld [DIV_STEPS];
	logic [DIV_STEPS:0] take;
	pixel_t             res_d, res_q;
	logic               res_vld_q;

	assign take[DIV_STEPS] = !res_vld_q || out_ready;
	assign in_ready        = take[0];

	always_comb begin
		prev[0].rem    = in_word.num;
		prev[0].quo    = '0;
		prev[0].den    = in_word.den;
		prev[0].bypass = in_word.bypass;
		prev[0].oa     = in_word.oa;
		prev[0].pix    = in_word.pix;
		prev_vld[0]    = in_valid;
		for (int k = 1; k < DIV_STEPS; k++) begin
			prev[k]     = div_s[k-1];
			prev_vld[k] = div_vld_s[k-1];
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int SHIFT = DIV_STEPS - 1 - k;
		div_step_t         nxt;
		logic [NUM_W-1:0]  dsh;

		assign take[k] = !div_vld_s[k] || take[k+1];

		always_comb begin
			dsh = NUM_W'(prev[k].den) << SHIFT;
			nxt = prev[k];
			for (int c = 0; c < NUM_CH; c++) begin
				if (prev[k].rem[c] >= dsh) begin
					nxt.rem[c]        = prev[k].rem[c] - dsh;
					nxt.quo[c][SHIFT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (take[k]) begin
				div_vld_s[k] <= prev_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (take[k] && prev_vld[k]) div_s[k] <= nxt;
		end
	end

	// quotient above 255 saturates; zero coverage passes the pixel through
	always_comb begin
		logic [NUM_CH-1:0][CHAN_W-1:0] ch;
		for (int c = 0; c < NUM_CH; c++) begin
			ch[c] = (div_s[DIV_STEPS-1].quo[c][QUO_W-1:CHAN_W] != '0) ? CHAN_MAX
				: div_s[DIV_STEPS-1].quo[c][CHAN_W-1:0];
		end
		if (div_s[DIV_STEPS-1].bypass) begin
			res_d = div_s[DIV_STEPS-1].pix;
		end else begin
			res_d.color.red   = ch[0];
			res_d.color.green = ch[1];
			res_d.color.blue  = ch[2];
			res_d.alpha       = div_s[DIV_STEPS-1].oa;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (take[DIV_STEPS]) begin
			res_vld_q <= div_vld_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (take[DIV_STEPS] && div_vld_s[DIV_STEPS-1]) res_q <= res_d;
	end

	assign out_valid = res_vld_q;
	assign out_pix   = res_q;

endmodule

FILE: rtl/core/straight_alpha_over_blend.sv
// Top level of the straight-alpha over blend: layer color registers and the pipeline.
// Depends on sob_pkg, sob_front and sob_div.
//
// Composites a solid layer color over one straight-alpha RGBA destination pixel,
// weighted by an 8-bit coverage. One word in, one word out, in order.
//
// Channels: input word (coverage, dest_*) on in_valid/in_ready, result word
// (out_*) on out_valid/out_ready. A word moves when valid and ready are both high.
// Layer color is set through cfg_we/cfg_index/cfg_data: index 0 red, 1 green,
// 2 blue; other indexes are ignored. Write it only while the pipe is empty.
//
// Pipeline: 14 register stages: 3 front stages (products, reciprocal alpha divide,
// numerator), 10 restoring divider stages with one quotient bit each, and the output reg.
// Throughput: one word per cycle while the receiver is ready, no dependence between words.
//
// Reset clears all valid bits and the layer color to zero; the pipe comes up empty.
// When the receiver stalls, each stage holds its word; empty stages in front
// still fill, so in_ready drops only once every stage holds a word.
module straight_alpha_over_blend (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sob_pkg::CHAN_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sob_pkg::CHAN_W-1:0]     coverage,
	input  logic [sob_pkg::CHAN_W-1:0]     dest_red,
	input  logic [sob_pkg::CHAN_W-1:0]     dest_green,
	input  logic [sob_pkg::CHAN_W-1:0]     dest_blue,
	input  logic [sob_pkg::CHAN_W-1:0]     dest_alpha,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sob_pkg::CHAN_W-1:0]     out_red,
	output logic [sob_pkg::CHAN_W-1:0]     out_green,
	output logic [sob_pkg::CHAN_W-1:0]     out_blue,
	output logic [sob_pkg::CHAN_W-1:0]     out_alpha
);
	import sob_pkg::*;

	rgb_t    layer_q;
	pixel_t  pix_in;
	pixel_t  pix_out;
	div_in_t front_word;
	logic    front_valid;
	logic    front_ready;

	// layer color registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LAYER_RED:   layer_q.red   <= cfg_data;
				REG_LAYER_GREEN: layer_q.green <= cfg_data;
				REG_LAYER_BLUE:  layer_q.blue  <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign pix_in.color.red   = dest_red;
	assign pix_in.color.green = dest_green;
	assign pix_in.color.blue  = dest_blue;
	assign pix_in.alpha       = dest_alpha;

	// products, output alpha, numerator/denominator
	sob_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cov_in    (coverage),
		.pix_in    (pix_in),
		.layer     (layer_q),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_word  (front_word)
	);

	// per-channel divide, clamp, pass-through, output register
	sob_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_word   (front_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pix   (pix_out)
	);

	assign out_red   = pix_out.color.red;
	assign out_green = pix_out.color.green;
	assign out_blue  = pix_out.color.blue;
	assign out_alpha = pix_out.alpha;

endmodule

FILE: bench/tb_straight_alpha_over_blend.sv
// Testbench for straight_alpha_over_blend: directed and random pixel words, checked
// against an in-bench integer blend model through a small scoreboard class.
// Depends on sob_pkg and the RTL of straight_alpha_over_blend.
module tb_straight_alpha_over_blend;
	import sob_pkg::*;

	// register index past the color registers; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int PIPE_LATENCY = 14;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 165;
	localparam int DIRECTED_WORDS = 12;

	// Holds the layer color as last written and the blended pixels still owed
	// by the block, oldest first.
	class blend_scoreboard;
		logic [CHAN_W-1:0] layer_red = '0;
		logic [CHAN_W-1:0] layer_green = '0;
		logic [CHAN_W-1:0] layer_blue = '0;
		pixel_t owed_pixels[$];
		int errors = 0;

		// one color channel: rounded weighted mean, saturated at 255
		function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] src,
				logic [CHAN_W-1:0] dst, logic [CHAN_W-1:0] cov,
				logic [CHAN_W-1:0] da, int unsigned oa);
			int unsigned den;
			int unsigned num;
			int unsigned quo;
			den = oa * 255;
			num = int'(src) * int'(cov) * 255 + int'(dst) * int'(da) * (255 - int'(cov))
				+ den / 2;
			quo = num / den;
			return (quo > 255) ? CHAN_MAX : quo[CHAN_W-1:0];
		endfunction

		function automatic pixel_t blend_pixel(logic [CHAN_W-1:0] cov,
				logic [CHAN_W-1:0] dr, logic [CHAN_W-1:0] dg,
				logic [CHAN_W-1:0] db, logic [CHAN_W-1:0] da);
			pixel_t p;
			int unsigned oa;
			p.color.red = dr;
			p.color.green = dg;
			p.color.blue = db;
			p.alpha = da;
			// no coverage: destination goes through untouched
			if (cov == 0)
				return p;
			oa = int'(cov) + (int'(da) * (255 - int'(cov)) + 127) / 255;
			if (oa == 0)
				return p;
			if (oa > 255)
				oa = 255;
			p.color.red = mix_channel(layer_red, dr, cov, da, oa);
			p.color.green = mix_channel(layer_green, dg, cov, da, oa);
			p.color.blue = mix_channel(layer_blue, db, cov, da, oa);
			p.alpha = oa[CHAN_W-1:0];
			return p;
		endfunction

		function void note_input(logic [CHAN_W-1:0] cov, logic [CHAN_W-1:0] dr,
				logic [CHAN_W-1:0] dg, logic [CHAN_W-1:0] db, logic [CHAN_W-1:0] da);
			owed_pixels = {owed_pixels, blend_pixel(cov, dr, dg, db, da)};
		endfunction

		function void compare_field(string field, logic [CHAN_W-1:0] want,
				logic [CHAN_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
				logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
			pixel_t want;
			if (owed_pixels.size() == 0) begin
				$error("result word with no pixel outstanding: %0d %0d %0d %0d", r, g, b, a);
				errors++;
				return;
			end
			want = owed_pixels.pop_front();
			compare_field("out_red", want.color.red, r);
			compare_field("out_green", want.color.green, g);
			compare_field("out_blue", want.color.blue, b);
			compare_field("out_alpha", want.alpha, a);
		endfunction

		function int outstanding();
			return owed_pixels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CHAN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CHAN_W-1:0] coverage = '0;
	logic [CHAN_W-1:0] dest_red = '0;
	logic [CHAN_W-1:0] dest_green = '0;
	logic [CHAN_W-1:0] dest_blue = '0;
	logic [CHAN_W-1:0] dest_alpha = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic [CHAN_W-1:0] out_alpha;

	blend_scoreboard sb;
	int cycle_count = 0;
	int burst_left = 0;
	int rx_mode = 0;

	straight_alpha_over_blend i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coverage   (coverage),
		.dest_red   (dest_red),
		.dest_green (dest_green),
		.dest_blue  (dest_blue),
		.dest_alpha (dest_alpha),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_alpha  (out_alpha)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver. It switches between stall patterns: always ready,
	// coin flip, mostly stalled, or a fixed periodic stall. Values read here are
	// the ones in place before this edge, so the accept test is race free.
	always @(posedge clk) begin
		if (cycle_count % 200 == 0)
			rx_mode <= $urandom_range(3);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(1));
			2: out_ready <= ($urandom_range(9) < 2);
			default: out_ready <= (cycle_count % 7 >= 3);
		endcase
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_red, out_green, out_blue, out_alpha);
	end

	// Byte biased toward the corners: zero, full scale and tiny values show up
	// far more often than a flat draw would give them.
	function automatic logic [CHAN_W-1:0] skewed_byte();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return CHAN_MAX;
			2: return 8'($urandom_range(3));
			3: return 8'($urandom_range(255, 250));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Present one pixel word and hold it until accepted. Returns on the accept
	// edge with valid still high, so a following word goes out back to back;
	// at the end of a burst valid may instead drop for a random gap first.
	task automatic send_pixel(input logic [CHAN_W-1:0] cov, input logic [CHAN_W-1:0] dr,
			input logic [CHAN_W-1:0] dg, input logic [CHAN_W-1:0] db,
			input logic [CHAN_W-1:0] da);
		int gap;
		in_valid <= 1'b1;
		coverage <= cov;
		dest_red <= dr;
		dest_green <= dg;
		dest_blue <= db;
		dest_alpha <= da;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(cov, dr, dg, db, da);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			case ($urandom_range(3))
				0, 1: gap = 0;
				2: gap = $urandom_range(4, 1);
				default: gap = $urandom_range(25, 5);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(40, 1);
		end
	endtask

	// Stop sending and wait for every owed word, then let the pipe settle.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Load the layer color, one register per cycle, plus a junk write to the
	// spare index which must change nothing. Pipe is idle when this runs.
	task automatic load_layer(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		cfg_we <= 1'b1;
		cfg_index <= REG_LAYER_RED;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_LAYER_GREEN;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= REG_LAYER_BLUE;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= 8'($urandom_range(255));
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.layer_red = r;
		sb.layer_green = g;
		sb.layer_blue = b;
	endtask

	// {coverage, red, green, blue, alpha}
	logic [5*CHAN_W-1:0] corner_pixels [DIRECTED_WORDS] = '{
		{8'd0,   8'd12,  8'd34,  8'd56,  8'd78},   // no coverage, passthrough
		{8'd0,   8'd255, 8'd255, 8'd255, 8'd255},  // no coverage, all ones
		{8'd0,   8'd0,   8'd0,   8'd0,   8'd0},    // no coverage over empty pixel
		{8'd255, 8'd0,   8'd0,   8'd0,   8'd0},    // full coverage over empty pixel
		{8'd255, 8'd255, 8'd255, 8'd255, 8'd255},  // full coverage over opaque white
		{8'd1,   8'd255, 8'd255, 8'd255, 8'd0},    // faint coverage, transparent dest
		{8'd1,   8'd0,   8'd0,   8'd0,   8'd255},  // faint coverage, opaque dest
		{8'd128, 8'd200, 8'd100, 8'd50,  8'd128},
		{8'd254, 8'd255, 8'd0,   8'd255, 8'd1},
		{8'd2,   8'd255, 8'd255, 8'd255, 8'd1},    // tiny alpha, rounding near clamp
		{8'd127, 8'd0,   8'd255, 8'd0,   8'd255},
		{8'd64,  8'd255, 8'd255, 8'd255, 8'd64}
	};

	initial begin
		logic [5*CHAN_W-1:0] w;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases, first with the reset color, then with white
		foreach (corner_pixels[i]) begin
			w = corner_pixels[i];
			send_pixel(w[39:32], w[31:24], w[23:16], w[15:8], w[7:0]);
		end
		drain_pipe();
		load_layer(CHAN_MAX, CHAN_MAX, CHAN_MAX);
		foreach (corner_pixels[i]) begin
			w = corner_pixels[i];
			send_pixel(w[39:32], w[31:24], w[23:16], w[15:8], w[7:0]);
		end

		// random phases; each one drains fully before the color changes
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_pipe();
			case (ph)
				0: load_layer(CHAN_MAX, 8'd0, CHAN_MAX);
				1: load_layer(8'd0, CHAN_MAX, 8'd0);
				2: load_layer(8'd0, 8'd0, 8'd0);
				default: load_layer(skewed_byte(), skewed_byte(), skewed_byte());
			endcase
			repeat (WORDS_PER_PHASE)
				send_pixel(skewed_byte(), skewed_byte(), skewed_byte(), skewed_byte(),
					skewed_byte());
		end
		drain_pipe();

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
